FILE: rtl/bpms_pkg.sv
// ----------------------------------------------------------------------------
// bpms_pkg
// shared types and constants of the budgeted periodic message scheduler
// ----------------------------------------------------------------------------
package bpms_pkg;

  localparam int unsigned MaxGroups  = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned PeriodW    = 32;
  localparam int unsigned SizeW      = 8;
  localparam int unsigned MaskW      = 16;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 40;

  localparam logic [SizeW-1:0] BudgetReset = 8'd20;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef struct packed {
    logic            wr_entry;
    logic            tick_start;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            proc_en;
    logic [IdxW-1:0] proc_addr;
    logic            load_out;
  } dp_cmd_t;

endpackage

FILE: rtl/bpms_ctrl.sv
// ----------------------------------------------------------------------------
// bpms_ctrl
// controller: accepts items, walks the groups in priority order, hands out
// the result item
// ----------------------------------------------------------------------------
module bpms_ctrl #(
  parameter int unsigned GROUP_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_command,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bpms_pkg::dp_cmd_t cmd
);

  localparam int unsigned NG = (GROUP_COUNT < bpms_pkg::MaxGroups) ?
                               GROUP_COUNT : bpms_pkg::MaxGroups;
  localparam int unsigned IW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NG - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] proc_idx_r;
  logic          proc_vld_r;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.rd_addr    = bpms_pkg::IdxW'(rd_idx_r);
    cmd.proc_addr  = bpms_pkg::IdxW'(proc_idx_r);
    cmd.proc_en    = proc_vld_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_command == bpms_pkg::CmdWrite) begin
            cmd.wr_entry = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            cmd.tick_start = 1'b1;
            rd_idx_nxt     = '0;
            state_nxt      = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.rd_en = 1'b1;
        if (rd_idx_r == LastIdx) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      proc_vld_r  <= (state_r == ST_WALK);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= rd_idx_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/bpms_dp.sv
// ----------------------------------------------------------------------------
// bpms_dp
// datapath: group tables, pending flags, budget and per-group send decision
// ----------------------------------------------------------------------------
module bpms_dp #(
  parameter int unsigned GROUP_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpms_pkg::dp_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [bpms_pkg::SizeW-1:0]        cfg_wdata,
  input  logic [bpms_pkg::IdxW-1:0]         wr_index,
  input  logic [bpms_pkg::PeriodW-1:0]      wr_period,
  input  logic [bpms_pkg::SizeW-1:0]        wr_size,
  output logic [bpms_pkg::OutDataW-1:0]     out_data
);

  localparam int unsigned NG = (GROUP_COUNT < bpms_pkg::MaxGroups) ?
                               GROUP_COUNT : bpms_pkg::MaxGroups;
  localparam int unsigned IW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [bpms_pkg::IdxW:0] NgLimit = (bpms_pkg::IdxW + 1)'(NG);

  logic [bpms_pkg::PeriodW-1:0] period_mem [NG];
  logic [bpms_pkg::SizeW-1:0]   size_mem   [NG];
  logic [bpms_pkg::PeriodW-1:0] phase_mem  [NG];

  logic [NG-1:0]                valid_r;
  logic [NG-1:0]                pend_r;
  logic [NG-1:0]                sent_r;
  logic [bpms_pkg::SizeW-1:0]   budget_r;
  logic [bpms_pkg::SizeW-1:0]   left_r;
  logic [bpms_pkg::PeriodW-1:0] per_q, ph_q;
  logic [bpms_pkg::SizeW-1:0]   sz_q;
  logic [bpms_pkg::OutDataW-1:0] out_r;

  logic [IW-1:0]                wa, pa, ra;
  logic                         wr_ok;
  logic                         en, due, fits, wrap;
  logic [bpms_pkg::PeriodW-1:0] ph_nxt;

  assign wa    = wr_index[IW-1:0];
  assign pa    = cmd.proc_addr[IW-1:0];
  assign ra    = cmd.rd_addr[IW-1:0];
  assign wr_ok = cmd.wr_entry && ({1'b0, wr_index} < NgLimit);

  assign en     = cmd.proc_en && valid_r[pa] && (per_q != '0);
  assign due    = en && ((ph_q == '0) || pend_r[pa]);
  assign fits   = (left_r >= sz_q);
  assign wrap   = (ph_q >= (per_q - 1'b1));
  assign ph_nxt = wrap ? '0 : ph_q + 1'b1;

  // group tables
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      period_mem[wa] <= wr_period;
      size_mem[wa]   <= wr_size;
    end
    if (cmd.rd_en) begin
      per_q <= period_mem[ra];
      sz_q  <= size_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      phase_mem[wa] <= '0;
    end else if (en) begin
      phase_mem[pa] <= ph_nxt;
    end
    if (cmd.rd_en) begin
      ph_q <= phase_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      pend_r   <= '0;
      budget_r <= bpms_pkg::BudgetReset;
    end else begin
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
      if (wr_ok) begin
        valid_r[wa] <= 1'b1;
        pend_r[wa]  <= 1'b0;
      end else if (due) begin
        pend_r[pa] <= !fits;
      end
    end
  end

  // per-tick accumulators
  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      left_r <= '0;
      sent_r <= '0;
    end else if (cmd.tick_start) begin
      left_r <= budget_r;
      sent_r <= '0;
    end else if (due && fits) begin
      left_r     <= left_r - sz_q;
      sent_r[pa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {left_r, bpms_pkg::MaskW'(pend_r), bpms_pkg::MaskW'(sent_r)};
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/budgeted_periodic_message_scheduler_top.sv
// ----------------------------------------------------------------------------
// budgeted_periodic_message_scheduler_top
// per-tick budgeted scheduler over up to 16 periodic message groups
// ----------------------------------------------------------------------------
// a tick walks the group tables one group per cycle, then hands out the result;
//   a group write skips the walk
// one item is in work at a time
// reset: all groups disabled, pending flags clear, budget 20, no tables cleared
module budgeted_periodic_message_scheduler_top #(
  parameter int unsigned GROUP_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command, group_index, period_value, byte_size, zero pad
  input  logic [bpms_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // sent_mask, pending_mask, bytes_left
  output logic [bpms_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [bpms_pkg::SizeW-1:0]    cfg_wdata
);

  bpms_pkg::dp_cmd_t cmd;

  bpms_ctrl #(
    .GROUP_COUNT(GROUP_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_command(in_tdata[0]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  bpms_dp #(
    .GROUP_COUNT(GROUP_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_index (in_tdata[4:1]),
    .wr_period(in_tdata[36:5]),
    .wr_size  (in_tdata[44:37]),
    .out_data (out_tdata)
  );

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_entry, cmd.tick_start, cmd.rd_en, cmd.load_out}))
    else $error("controller commands overlap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.load_out)
    else $error("result overwritten while stalled");

  a_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.proc_en) |-> !in_tready)
    else $error("item accepted during group walk");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_entry ##1 cmd.load_out) |=> (out_tdata[15:0] == '0 && out_tdata[39:32] == '0))
    else $error("write result carries sends or budget");

endmodule

FILE: sim/budgeted_periodic_message_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// budgeted_periodic_message_scheduler_top_test
// Drives group writes and scheduling ticks into the scheduler under random
// stalls on both streams. A behavioral copy of the group tables predicts the
// sent mask, pending mask and leftover budget of every item, and each result
// is checked field by field. The byte budget is changed between phases,
// including its extremes.
// ----------------------------------------------------------------------------
module budgeted_periodic_message_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Groups     = bpms_pkg::MaxGroups;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [bpms_pkg::SizeW-1:0] bytes_left;
    logic [bpms_pkg::MaskW-1:0] pending_mask;
    logic [bpms_pkg::MaskW-1:0] sent_mask;
  } sched_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [bpms_pkg::InDataW-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [bpms_pkg::OutDataW-1:0] out_tdata;
  logic                          cfg_we;
  logic [bpms_pkg::SizeW-1:0]    cfg_wdata;

  logic [bpms_pkg::PeriodW-1:0] grp_period [Groups];
  logic [bpms_pkg::SizeW-1:0]   grp_size [Groups];
  logic [bpms_pkg::PeriodW-1:0] grp_phase [Groups];
  logic                         grp_pending [Groups];
  logic [bpms_pkg::SizeW-1:0]   budget_now;

  sched_result_t sched_q [$];
  bit            gaps_on;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  budgeted_periodic_message_scheduler_top #(
    .GROUP_COUNT(Groups)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 17);
  end

  // schedule one item against the table copy
  function automatic sched_result_t schedule_step(logic [bpms_pkg::InDataW-1:0] item);
    logic                         cmd;
    logic [bpms_pkg::IdxW-1:0]    idx;
    logic [bpms_pkg::PeriodW-1:0] period;
    logic [bpms_pkg::SizeW-1:0]   size;
    logic [bpms_pkg::SizeW-1:0]   left;
    sched_result_t                res;
    cmd    = item[0];
    idx    = item[4:1];
    period = item[36:5];
    size   = item[44:37];
    res    = '0;
    if (cmd == bpms_pkg::CmdWrite) begin
      if (idx < Groups) begin
        grp_period[idx]  = period;
        grp_size[idx]    = size;
        grp_phase[idx]   = '0;
        grp_pending[idx] = 1'b0;
      end
    end else begin
      left = budget_now;
      for (int g = 0; g < Groups; g++) begin
        if (grp_period[g] != '0) begin
          if (grp_phase[g] == '0 || grp_pending[g]) begin
            if (left >= grp_size[g]) begin
              left             = left - grp_size[g];
              grp_pending[g]   = 1'b0;
              res.sent_mask[g] = 1'b1;
            end else begin
              grp_pending[g] = 1'b1;
            end
          end
          if (grp_phase[g] >= grp_period[g] - 32'd1) begin
            grp_phase[g] = '0;
          end else begin
            grp_phase[g] = grp_phase[g] + 32'd1;
          end
        end
      end
      res.bytes_left = left;
    end
    for (int g = 0; g < Groups; g++) begin
      res.pending_mask[g] = grp_pending[g];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (sched_q.size() == 0) begin
        if (fail_count < ReportMax) begin
          $display("unexpected result: sent %h pending %h left %h",
                   got.sent_mask, got.pending_mask, got.bytes_left);
        end
        fail_count++;
      end else begin
        want = sched_q.pop_front();
        if (got.sent_mask != want.sent_mask || got.pending_mask != want.pending_mask ||
            got.bytes_left != want.bytes_left) begin
          if (fail_count < ReportMax) begin
            $display("mismatch: exp sent %h pending %h left %h, got sent %h pending %h left %h",
                     want.sent_mask, want.pending_mask, want.bytes_left,
                     got.sent_mask, got.pending_mask, got.bytes_left);
          end
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [bpms_pkg::InDataW-1:0] item);
    if (gaps_on) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
    sched_q.push_back(schedule_step(item));
  endtask

  task automatic write_group(input logic [bpms_pkg::IdxW-1:0]    idx,
                             input logic [bpms_pkg::PeriodW-1:0] period,
                             input logic [bpms_pkg::SizeW-1:0]   size);
    send_item({3'b000, size, period, idx, bpms_pkg::CmdWrite});
  endtask

  task automatic tick();
    send_item({3'b000, 8'h00, 32'h0000_0000, 4'h0, bpms_pkg::CmdTick});
  endtask

  task automatic set_budget(input logic [bpms_pkg::SizeW-1:0] value);
    in_tvalid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    budget_now = value;
  endtask

  function automatic logic [bpms_pkg::InDataW-1:0] random_item();
    logic [bpms_pkg::PeriodW-1:0] period;
    logic [bpms_pkg::SizeW-1:0]   size;
    int unsigned                  pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      period = '0;
    end else if (pick < 80) begin
      period = $urandom_range(8, 1);
    end else if (pick < 92) begin
      period = $urandom_range(64, 9);
    end else begin
      period = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      size = 8'($urandom_range(12, 0));
    end else if (pick < 90) begin
      size = 8'($urandom_range(40, 13));
    end else begin
      size = 8'($urandom_range(255, 0));
    end
    // ticks carry random noise in the unused fields
    if ($urandom_range(99) < 25) begin
      return {3'b000, size, period, 4'($urandom_range(15, 0)), bpms_pkg::CmdWrite};
    end
    return {3'b000, size, period, 4'($urandom_range(15, 0)), bpms_pkg::CmdTick};
  endfunction

  task automatic test_idle_tick();
    tick();
    tick();
  endtask

  task automatic test_entry_extremes();
    write_group(4'd0, 32'd1, 8'd0);
    write_group(4'd15, 32'hFFFF_FFFF, 8'hFF);
    write_group(4'd7, 32'd2, 8'd20);
    tick();
    tick();
    tick();
    write_group(4'd3, 32'd3, 8'd21);
    tick();
    write_group(4'd15, 32'd0, 8'd0);
    tick();
  endtask

  task automatic test_budget_extremes();
    set_budget(8'd0);
    tick();
    tick();
    set_budget(8'd255);
    write_group(4'd15, 32'd5, 8'd255);
    tick();
    tick();
  endtask

  task automatic test_random_phase(input logic [bpms_pkg::SizeW-1:0] budget, input bit gaps,
                                   input int unsigned count);
    set_budget(budget);
    gaps_on = gaps;
    repeat (count) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int g = 0; g < Groups; g++) begin
      grp_period[g]  = '0;
      grp_size[g]    = '0;
      grp_phase[g]   = '0;
      grp_pending[g] = 1'b0;
    end
    budget_now  = bpms_pkg::BudgetReset;
    gaps_on     = 1'b1;
    fail_count  = 0;
    cycle_count = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_tick();
    test_entry_extremes();
    test_budget_extremes();
    test_random_phase(8'd20, 1'b1, 200);
    test_random_phase(8'd0, 1'b1, 150);
    test_random_phase(8'd255, 1'b0, 250);
    test_random_phase(8'($urandom_range(255, 0)), 1'b1, 200);
    test_random_phase(8'($urandom_range(30, 1)), 1'b1, 200);
    test_random_phase(8'd20, 1'b1, 150);

    in_tvalid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (Groups + 8) @(posedge clk);
    if (sched_q.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bpms_pkg.sv
rtl/bpms_ctrl.sv
rtl/bpms_dp.sv
rtl/budgeted_periodic_message_scheduler_top.sv
sim/budgeted_periodic_message_scheduler_top_test.sv
